/* rtl/assert_macros.svh */
// Assertion macros shared by the rotation matrix RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, held off in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* rtl/e2rm_pkg.sv */
// Package for the Euler-to-rotation-matrix block: widths, CORDIC table, helpers.
// Depends on nothing; used by every module under rtl.
package e2rm_pkg;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int PORT_BITS      = 16;
   localparam int STEPS          = 30;
   localparam int WBITS          = 34;   // Q2.30 plus guard for CORDIC gain
   localparam int MUL_LAT        = 2;    // two product levels
   localparam logic signed [WBITS-1:0] CORDIC_K = 34'sd652032874;

   typedef logic signed [WBITS-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      logic     flip;
   } cell_type;

   function automatic word_type angle_tab(input int i);
      word_type t;
      case (i)
         0: t = 34'sd536870912;   1: t = 34'sd316933406;
         2: t = 34'sd167458907;   3: t = 34'sd85004756;
         4: t = 34'sd42667331;    5: t = 34'sd21354465;
         6: t = 34'sd10679838;    7: t = 34'sd5340245;
         8: t = 34'sd2670163;     9: t = 34'sd1335087;
         10: t = 34'sd667544;     11: t = 34'sd333772;
         12: t = 34'sd166886;     13: t = 34'sd83443;
         14: t = 34'sd41722;      15: t = 34'sd20861;
         16: t = 34'sd10430;      17: t = 34'sd5215;
         18: t = 34'sd2608;       19: t = 34'sd1304;
         20: t = 34'sd652;        21: t = 34'sd326;
         22: t = 34'sd163;        23: t = 34'sd81;
         24: t = 34'sd41;         25: t = 34'sd20;
         26: t = 34'sd10;         27: t = 34'sd5;
         28: t = 34'sd3;          29: t = 34'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

   // rounded Q2.30 product: floor((a*b + 2^29) / 2^30)
   function automatic word_type qmul(input word_type a, input word_type b);
      logic signed [2*WBITS-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      return word_type'(p >>> 30);
   endfunction
endpackage

/* rtl/e2rm_cell.sv */
// One CORDIC rotation cell; registers x, y, z and the flip flag each cycle.
// Depends on e2rm_pkg.
module e2rm_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  e2rm_pkg::cell_type   cell_in,
   output e2rm_pkg::cell_type   cell_out
);
   e2rm_pkg::cell_type cell_ff, cell_in_w;
   e2rm_pkg::word_type dx, dy;

   // micro-rotation toward z = 0
   always_comb begin
      dx = cell_in.y >>> STEP;
      dy = cell_in.x >>> STEP;
      cell_in_w.flip = cell_in.flip;
      if (!cell_in.z[e2rm_pkg::WBITS-1]) begin
         cell_in_w.x = cell_in.x - dx;
         cell_in_w.y = cell_in.y + dy;
         cell_in_w.z = cell_in.z - e2rm_pkg::angle_tab(STEP);
      end else begin
         cell_in_w.x = cell_in.x + dx;
         cell_in_w.y = cell_in.y - dy;
         cell_in_w.z = cell_in.z + e2rm_pkg::angle_tab(STEP);
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_w;
   end
   assign cell_out = cell_ff;
endmodule

/* rtl/e2rm_sincos.sv */
// Sine/cosine of one binary angle: quadrant fold then a chain of CORDIC cells.
// Depends on e2rm_pkg and e2rm_cell.
module e2rm_sincos #(
   parameter int ANGLE_BITS = e2rm_pkg::ANGLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic [e2rm_pkg::PORT_BITS-1:0]        angle,
   output e2rm_pkg::word_type                    sin_q,
   output e2rm_pkg::word_type                    cos_q
);
   e2rm_pkg::cell_type chain [0:e2rm_pkg::STEPS];
   e2rm_pkg::cell_type head;
   logic [31:0] a, af;
   logic        flip;

   // map into [-pi/2, pi/2) as a 32-bit circle fraction
   always_comb begin
      a    = (32'(angle) & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
      flip = a[31] ^ a[30];
      af   = flip ? (a + 32'h8000_0000) : a;
      head.x    = e2rm_pkg::CORDIC_K;
      head.y    = '0;
      head.z    = e2rm_pkg::word_type'($signed(af));
      head.flip = flip;
   end

   assign chain[0] = head;

   for (genvar i = 0; i < e2rm_pkg::STEPS; i++) begin : g_cell
      e2rm_cell #(.STEP(i)) u_cell (
         .clock   (clock),
         .cell_in (chain[i]),
         .cell_out(chain[i+1])
      );
   end

   assign sin_q = chain[e2rm_pkg::STEPS].flip ? -chain[e2rm_pkg::STEPS].y
                                              :  chain[e2rm_pkg::STEPS].y;
   assign cos_q = chain[e2rm_pkg::STEPS].flip ? -chain[e2rm_pkg::STEPS].x
                                              :  chain[e2rm_pkg::STEPS].x;
endmodule

/* rtl/e2rm_matrix.sv */
// Products of sines and cosines into the nine rounded, saturated elements.
// Depends on e2rm_pkg.
module e2rm_matrix #(
   parameter int FRAC_BITS = e2rm_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  e2rm_pkg::word_type  sx, cx, sy, cy, sz, cz,
   output logic [e2rm_pkg::PORT_BITS-1:0] m_ff [0:8]
);
   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [e2rm_pkg::WBITS:0] LIM = (35'sd1 <<< FRAC_BITS);

   e2rm_pkg::word_type sxsy_ff, cxsy_ff, cz_ff, sz_ff, sy_ff;
   e2rm_pkg::word_type cycz_ff, cysz_ff, sxcy_ff, cxcy_ff;
   e2rm_pkg::word_type cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   logic signed [e2rm_pkg::WBITS:0] v [0:8];
   logic [e2rm_pkg::PORT_BITS-1:0] m_in [0:8];

   function automatic logic [e2rm_pkg::PORT_BITS-1:0] to_out(
      input logic signed [e2rm_pkg::WBITS:0] vin);
      logic signed [e2rm_pkg::WBITS:0] r;
      r = vin;
      if (SH > 0) r = (vin + (35'sd1 <<< (SH > 0 ? SH-1 : 0))) >>> SH;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      return r[e2rm_pkg::PORT_BITS-1:0];
   endfunction

   // first product level
   always_ff @(posedge clock) begin
      sxsy_ff <= e2rm_pkg::qmul(sx, sy);
      cxsy_ff <= e2rm_pkg::qmul(cx, sy);
      cycz_ff <= e2rm_pkg::qmul(cy, cz);
      cysz_ff <= e2rm_pkg::qmul(cy, sz);
      sxcy_ff <= e2rm_pkg::qmul(sx, cy);
      cxcy_ff <= e2rm_pkg::qmul(cx, cy);
      cxsz_ff <= e2rm_pkg::qmul(cx, sz);
      cxcz_ff <= e2rm_pkg::qmul(cx, cz);
      sxsz_ff <= e2rm_pkg::qmul(sx, sz);
      sxcz_ff <= e2rm_pkg::qmul(sx, cz);
      cz_ff <= cz; sz_ff <= sz; sy_ff <= sy;
   end

   // second level, sums and output conversion
   always_comb begin
      v[0] = 35'(cycz_ff);
      v[1] = 35'(cysz_ff);
      v[2] = -35'(sy_ff);
      v[3] = 35'(e2rm_pkg::qmul(sxsy_ff, cz_ff)) - 35'(cxsz_ff);
      v[4] = 35'(e2rm_pkg::qmul(sxsy_ff, sz_ff)) + 35'(cxcz_ff);
      v[5] = 35'(sxcy_ff);
      v[6] = 35'(e2rm_pkg::qmul(cxsy_ff, cz_ff)) + 35'(sxsz_ff);
      v[7] = 35'(e2rm_pkg::qmul(cxsy_ff, sz_ff)) - 35'(sxcz_ff);
      v[8] = 35'(cxcy_ff);
      for (int k = 0; k < 9; k++) m_in[k] = to_out(v[k]);
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end
endmodule

/* rtl/euler_to_rotation_matrix_top.sv */
// Euler angles to 3x3 rotation matrix (transpose of Rz*Ry*Rx), Q1.14 out.
// Depends on e2rm_pkg, e2rm_sincos, e2rm_matrix and assert_macros.svh.
//
// Usage:
//  - Raise start with req_pitch_angle, req_yaw_angle, req_roll_angle; a beat
//    is taken at each clock edge with start high (busy is always low).
//  - Three CORDIC chains of 30 cells each form sine and cosine, then two
//    product levels form the matrix elements.
//  - A beat runs through the cell, product and output registers to rsp_valid.
//    Throughput: one beat per cycle; the cell chains advance every clock.
//  - rsp_valid is high for one cycle with the nine elements; the receiver
//    cannot stall and must take the beat then.
//  - Synchronous reset clears the valid pipeline; beats in flight are lost.
`include "assert_macros.svh"
module euler_to_rotation_matrix_top #(
   parameter int ANGLE_BITS = e2rm_pkg::ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = e2rm_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_m_row0_col0, rsp_m_row0_col1, rsp_m_row0_col2,
   output logic signed [15:0] rsp_m_row1_col0, rsp_m_row1_col1, rsp_m_row1_col2,
   output logic signed [15:0] rsp_m_row2_col0, rsp_m_row2_col1, rsp_m_row2_col2
);
   localparam int LAT = e2rm_pkg::STEPS + e2rm_pkg::MUL_LAT;

   e2rm_pkg::word_type sx, cx, sy, cy, sz, cz;
   logic [15:0] m [0:8];
   logic [LAT-1:0] vld_ff, vld_in;

   assign busy = 1'b0;

   e2rm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_x (.clock(clock), .angle(req_pitch_angle),
      .sin_q(sx), .cos_q(cx));
   e2rm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_y (.clock(clock), .angle(req_yaw_angle),
      .sin_q(sy), .cos_q(cy));
   e2rm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_z (.clock(clock), .angle(req_roll_angle),
      .sin_q(sz), .cos_q(cz));

   e2rm_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (.clock(clock),
      .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz), .m_ff(m));

   // valid marker travels alongside the data
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_m_row0_col0 = m[0];
   assign rsp_m_row0_col1 = m[1];
   assign rsp_m_row0_col2 = m[2];
   assign rsp_m_row1_col0 = m[3];
   assign rsp_m_row1_col1 = m[4];
   assign rsp_m_row1_col2 = m[5];
   assign rsp_m_row2_col0 = m[6];
   assign rsp_m_row2_col1 = m[7];
   assign rsp_m_row2_col2 = m[8];

   `ASSERT_NEXT(a_vld_shift, clock, reset, vld_ff[0], vld_ff[1], "valid lost in pipe")
   `ASSERT_IMPLY(a_sat, clock, reset, rsp_valid,
      ($signed(rsp_m_row0_col2) <= 16'sd16384) && ($signed(rsp_m_row0_col2) >= -16'sd16384),
      "element out of range")
endmodule
